// ===== hw/rtl/mfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared types and constants of the multiplexed-connection frame deframer.
// ----------------------------------------------------------------------------
package mfd_pkg;

  // header layout
  localparam int HEADER_BYTES = 14;
  localparam int POS_W        = 4;
  localparam logic [POS_W-1:0] POS_MAGIC = 4'd0;
  localparam logic [POS_W-1:0] POS_FLAGS = 4'd1;
  localparam logic [POS_W-1:0] POS_LEN0  = 4'd10;
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(HEADER_BYTES - 1);

  // field widths
  localparam int BYTE_W   = 8;
  localparam int STREAM_W = 64;
  localparam int LEN_W    = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MAGIC = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 8'd1;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 32'd1048576;

  // result kinds
  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  // error codes
  localparam logic ERR_BAD_MAGIC = 1'b0;
  localparam logic ERR_TOO_LARGE = 1'b1;

  // one result item
  typedef struct packed {
    kind_t                kind;
    logic [BYTE_W-1:0]    frame_flags;
    logic [STREAM_W-1:0]  stream_number;
    logic [LEN_W-1:0]     payload_length;
    logic [BYTE_W-1:0]    out_byte;
    logic                 last;
    logic                 err_cause;
  } result_t;

endpackage

// ===== hw/rtl/mfd_if.sv =====
// ----------------------------------------------------------------------------
// mfd_if
// Valid/ready channel interfaces of the frame deframer: byte input,
// result output and configuration write.
// ----------------------------------------------------------------------------

// input byte channel
interface mfd_in_if;
  logic                       valid;
  logic                       ready;
  logic [mfd_pkg::BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// result channel
interface mfd_out_if;
  logic                         valid;
  logic                         ready;
  mfd_pkg::kind_t               kind;
  logic [mfd_pkg::BYTE_W-1:0]   frame_flags;
  logic [mfd_pkg::STREAM_W-1:0] stream_number;
  logic [mfd_pkg::LEN_W-1:0]    payload_length;
  logic [mfd_pkg::BYTE_W-1:0]   out_byte;
  logic                         last;
  logic                         err_cause;

  modport source (output valid, output kind, output frame_flags, output stream_number,
                  output payload_length, output out_byte, output last,
                  output err_cause, input ready);
  modport sink   (input valid, input kind, input frame_flags, input stream_number,
                  input payload_length, input out_byte, input last,
                  input err_cause, output ready);
endinterface

// configuration write channel
interface mfd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mfd_pkg::CFG_IDX_W-1:0]  index;
  logic [mfd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/mux_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// mux_frame_deframer_unit
// Byte-serial deframer: gathers a 14-byte frame header, checks it and
// passes the payload bytes through.
// ----------------------------------------------------------------------------
// Takes one byte of the connection stream per clock and gives at most one
// result per byte, in the cycle after the byte is accepted, from a single output
// register. A byte is accepted in every cycle in which the output register is
// empty or its result is being taken, so throughput is one byte per cycle with
// no bubbles; the only thing that slows the input is back-pressure on the
// result channel. Header bytes 1 to 13 give no result; the 14th gives a header
// result (last set for a zero-length frame) or an error result. Payload bytes
// come out one each, the final one with last set. After an error (bad magic,
// or a length above max_payload) every byte is taken and dropped until reset.
// Configuration writes are taken in any cycle and need no clearing pass.
// ----------------------------------------------------------------------------
module mux_frame_deframer_unit (
  input  logic            clk,
  input  logic            rst_n,
  mfd_in_if.sink          in_if,
  mfd_out_if.source       out_if,
  mfd_cfg_if.sink         cfg_if
);

  // configuration registers
  logic [mfd_pkg::BYTE_W-1:0]   frame_magic_r;
  logic [mfd_pkg::LEN_W-1:0]    max_payload_r;

  // frame state
  logic [mfd_pkg::POS_W-1:0]    header_count_r, header_count_nxt;
  logic                         magic_ok_r, magic_ok_nxt;
  logic [mfd_pkg::BYTE_W-1:0]   flags_r, flags_nxt;
  logic [mfd_pkg::STREAM_W-1:0] stream_r, stream_nxt;
  logic [mfd_pkg::LEN_W-1:0]    length_r, length_nxt;
  logic [mfd_pkg::LEN_W-1:0]    remaining_r, remaining_nxt;
  logic                         in_payload_r, in_payload_nxt;
  logic                         halted_r, halted_nxt;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  mfd_pkg::result_t             res_r, res_nxt;
  logic                         res_fire;

  logic in_accept;
  logic [mfd_pkg::BYTE_W-1:0] b;

  assign b          = in_if.in_byte;
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_accept  = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  // next state and result for the accepted byte
  always_comb begin
    header_count_nxt = header_count_r;
    magic_ok_nxt     = magic_ok_r;
    flags_nxt        = flags_r;
    stream_nxt       = stream_r;
    length_nxt       = length_r;
    remaining_nxt    = remaining_r;
    in_payload_nxt   = in_payload_r;
    halted_nxt       = halted_r;
    res_fire         = 1'b0;
    res_nxt          = '0;

    if (in_accept && !halted_r) begin
      if (in_payload_r) begin
        // payload pass-through
        remaining_nxt = remaining_r - 1'b1;
        if (remaining_r == mfd_pkg::LEN_W'(1)) begin
          in_payload_nxt = 1'b0;
        end
        res_fire = 1'b1;
        res_nxt.kind     = mfd_pkg::KIND_PAYLOAD;
        res_nxt.out_byte = b;
        res_nxt.last     = (remaining_r == mfd_pkg::LEN_W'(1));
      end else begin
        // header gathering
        if (header_count_r == mfd_pkg::POS_MAGIC) begin
          magic_ok_nxt = (b == frame_magic_r);
        end else if (header_count_r == mfd_pkg::POS_FLAGS) begin
          flags_nxt = b;
        end else if (header_count_r < mfd_pkg::POS_LEN0) begin
          stream_nxt = {stream_r[mfd_pkg::STREAM_W-mfd_pkg::BYTE_W-1:0], b};
        end else begin
          length_nxt = {length_r[mfd_pkg::LEN_W-mfd_pkg::BYTE_W-1:0], b};
        end

        if (header_count_r != mfd_pkg::POS_LAST) begin
          header_count_nxt = header_count_r + 1'b1;
        end else begin
          // header complete: check and report
          header_count_nxt = '0;
          res_fire = 1'b1;
          if (!magic_ok_r) begin
            halted_nxt         = 1'b1;
            res_nxt.kind       = mfd_pkg::KIND_ERROR;
            res_nxt.err_cause  = mfd_pkg::ERR_BAD_MAGIC;
          end else if (length_nxt > max_payload_r) begin
            halted_nxt         = 1'b1;
            res_nxt.kind       = mfd_pkg::KIND_ERROR;
            res_nxt.err_cause  = mfd_pkg::ERR_TOO_LARGE;
          end else begin
            res_nxt.kind = mfd_pkg::KIND_HEADER;
            if (length_nxt == '0) begin
              res_nxt.last = 1'b1;
            end else begin
              remaining_nxt  = length_nxt;
              in_payload_nxt = 1'b1;
            end
          end
        end
      end
    end

    res_nxt.frame_flags    = flags_nxt;
    res_nxt.stream_number  = stream_nxt;
    res_nxt.payload_length = length_nxt;

    // output register hand-off
    if (out_valid_r && !out_if.ready) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = res_fire;
    end
  end

  // state, configuration and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_magic_r  <= '0;
      max_payload_r  <= mfd_pkg::MAX_PAYLOAD_RST;
      header_count_r <= '0;
      magic_ok_r     <= 1'b0;
      flags_r        <= '0;
      stream_r       <= '0;
      length_r       <= '0;
      remaining_r    <= '0;
      in_payload_r   <= 1'b0;
      halted_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      header_count_r <= header_count_nxt;
      magic_ok_r     <= magic_ok_nxt;
      flags_r        <= flags_nxt;
      stream_r       <= stream_nxt;
      length_r       <= length_nxt;
      remaining_r    <= remaining_nxt;
      in_payload_r   <= in_payload_nxt;
      halted_r       <= halted_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_if.valid) begin
        unique case (cfg_if.index)
          mfd_pkg::CFG_FRAME_MAGIC: frame_magic_r <= cfg_if.data[mfd_pkg::BYTE_W-1:0];
          mfd_pkg::CFG_MAX_PAYLOAD: max_payload_r <= cfg_if.data[mfd_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // result payload, loaded only when a new result enters the register
  always_ff @(posedge clk) begin
    if (res_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.kind           = res_r.kind;
  assign out_if.frame_flags    = res_r.frame_flags;
  assign out_if.stream_number  = res_r.stream_number;
  assign out_if.payload_length = res_r.payload_length;
  assign out_if.out_byte       = res_r.out_byte;
  assign out_if.last           = res_r.last;
  assign out_if.err_cause      = res_r.err_cause;

endmodule

// ===== hw/rtl/mux_frame_deframer_unit_chk.sv =====
// ----------------------------------------------------------------------------
// mfd_chk
// Port-level checks of the frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module mfd_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input mfd_pkg::kind_t             out_kind,
  input logic [mfd_pkg::BYTE_W-1:0] out_byte,
  input logic                       out_last,
  input logic                       out_err_cause
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte)
      && $stable(out_last) && $stable(out_err_cause))
    else $error("stalled result changed");

  // an error halts the block: nothing follows it
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind == mfd_pkg::KIND_ERROR |=> !out_valid)
    else $error("result after protocol error");

  // an empty output register never blocks input
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // non-payload results carry no byte, errors are never last
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != mfd_pkg::KIND_PAYLOAD |->
      out_byte == '0 && (out_kind == mfd_pkg::KIND_HEADER || !out_last))
    else $error("bad field on header or error result");

  // payload and header results carry error cause zero
  a_err_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != mfd_pkg::KIND_ERROR |-> !out_err_cause)
    else $error("error cause set on non-error result");

endmodule

bind mux_frame_deframer_unit mfd_chk u_mfd_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_kind       (out_if.kind),
  .out_byte       (out_if.out_byte),
  .out_last       (out_if.last),
  .out_err_cause  (out_if.err_cause)
);

// ===== sim/tb_mux_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_mux_frame_deframer_unit
// Self-checking testbench of the frame deframer.
// A short table of directed bytes with hand-written results for the simplest
// frames comes first. Random well-formed frames under changing magic and
// length limits follow, with idle cycles on both sides and one long receiver
// stall. The run ends with one protocol error and bytes sent after the halt.
// Every other result is checked against an in-testbench model of the deframer.
// ----------------------------------------------------------------------------
module tb_mux_frame_deframer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mfd_pkg::*;

  localparam int RANDOM_ITEMS  = 2000;
  localparam int PHASE_ITEMS   = 250;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_CYCLES   = 400;
  localparam int TIMEOUT_NS    = 2_000_000;

  // index past the end of the register list, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'hFF;

  typedef enum int {END_BAD_MAGIC, END_TOO_LARGE, END_NOISE} ending_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              pinned;
    result_t           want;
  } directed_row_t;

  localparam result_t NO_PIN = '0;

  // directed bytes, fixed results only where they are obvious
  localparam directed_row_t DIRECTED_ROWS [29] = '{
    // zero-length frame, reset magic, all-ones flags and stream id
    '{8'h00, 1'b0, NO_PIN},
    '{8'hFF, 1'b0, NO_PIN},
    '{8'hFF, 1'b0, NO_PIN}, '{8'hFF, 1'b0, NO_PIN}, '{8'hFF, 1'b0, NO_PIN},
    '{8'hFF, 1'b0, NO_PIN}, '{8'hFF, 1'b0, NO_PIN}, '{8'hFF, 1'b0, NO_PIN},
    '{8'hFF, 1'b0, NO_PIN}, '{8'hFF, 1'b0, NO_PIN},
    '{8'h00, 1'b0, NO_PIN}, '{8'h00, 1'b0, NO_PIN}, '{8'h00, 1'b0, NO_PIN},
    '{8'h00, 1'b1, '{KIND_HEADER, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0,
                     8'h00, 1'b1, 1'b0}},
    // one-byte frame, zero flags, stream id with both end bits set
    '{8'h00, 1'b0, NO_PIN},
    '{8'h00, 1'b0, NO_PIN},
    '{8'h80, 1'b0, NO_PIN}, '{8'h00, 1'b0, NO_PIN}, '{8'h00, 1'b0, NO_PIN},
    '{8'h00, 1'b0, NO_PIN}, '{8'h00, 1'b0, NO_PIN}, '{8'h00, 1'b0, NO_PIN},
    '{8'h00, 1'b0, NO_PIN}, '{8'h01, 1'b0, NO_PIN},
    '{8'h00, 1'b0, NO_PIN}, '{8'h00, 1'b0, NO_PIN}, '{8'h00, 1'b0, NO_PIN},
    '{8'h01, 1'b1, '{KIND_HEADER, 8'h00, 64'h8000_0000_0000_0001, 32'd1,
                     8'h00, 1'b0, 1'b0}},
    '{8'hFF, 1'b1, '{KIND_PAYLOAD, 8'h00, 64'h8000_0000_0000_0001, 32'd1,
                     8'hFF, 1'b1, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst_n;

  mfd_in_if  in_ch ();
  mfd_out_if out_ch ();
  mfd_cfg_if cfg_ch ();

  mux_frame_deframer_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #1 clk = ~clk;

  // deframer model state and register copies
  logic [POS_W-1:0]    hdr_pos        = '0;
  logic                magic_match    = 1'b0;
  logic [BYTE_W-1:0]   flags_q        = '0;
  logic [STREAM_W-1:0] stream_q       = '0;
  logic [LEN_W-1:0]    length_q       = '0;
  logic [LEN_W-1:0]    bytes_left     = '0;
  logic                payload_active = 1'b0;
  logic                stopped        = 1'b0;
  logic [BYTE_W-1:0]   magic_cfg      = '0;
  logic [LEN_W-1:0]    max_len_cfg    = MAX_PAYLOAD_RST;

  result_t pending_results [$];
  int      mismatches = 0;

  // directed rows with a fixed result
  logic    pin_active = 1'b0;
  result_t pin_res    = '0;

  // idle rates and receiver stall requests
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int items_sent    = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // one byte through the deframer model, returns 1 when it gives a result
  function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output result_t res);
    res = '0;
    if (stopped)
      return 1'b0;

    // payload pass-through
    if (payload_active) begin
      bytes_left = bytes_left - 1'b1;
      if (bytes_left == '0)
        payload_active = 1'b0;
      res = '{KIND_PAYLOAD, flags_q, stream_q, length_q, b, bytes_left == '0, 1'b0};
      return 1'b1;
    end

    // header gathering, big-endian fields
    case (hdr_pos)
      POS_MAGIC: magic_match = (b == magic_cfg);
      POS_FLAGS: flags_q = b;
      default: begin
        if (hdr_pos < POS_LEN0)
          stream_q = {stream_q[STREAM_W-BYTE_W-1:0], b};
        else
          length_q = {length_q[LEN_W-BYTE_W-1:0], b};
      end
    endcase
    if (hdr_pos != POS_LAST) begin
      hdr_pos = hdr_pos + 1'b1;
      return 1'b0;
    end

    // header complete: magic first, then length limit
    hdr_pos = '0;
    if (!magic_match) begin
      stopped = 1'b1;
      res = '{KIND_ERROR, flags_q, stream_q, length_q, 8'h00, 1'b0, ERR_BAD_MAGIC};
      return 1'b1;
    end
    if (length_q > max_len_cfg) begin
      stopped = 1'b1;
      res = '{KIND_ERROR, flags_q, stream_q, length_q, 8'h00, 1'b0, ERR_TOO_LARGE};
      return 1'b1;
    end
    if (length_q != '0) begin
      bytes_left     = length_q;
      payload_active = 1'b1;
    end
    res = '{KIND_HEADER, flags_q, stream_q, length_q, 8'h00, length_q == '0, 1'b0};
    return 1'b1;
  endfunction

  // transaction monitor and result checker
  always @(posedge clk) begin : scoreboard
    result_t res;
    result_t seen;
    result_t want;
    bit      produced;
    if (rst_n === 1'b1) begin
      // register write transaction
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
        case (cfg_ch.index)
          CFG_FRAME_MAGIC: magic_cfg = cfg_ch.data[BYTE_W-1:0];
          CFG_MAX_PAYLOAD: max_len_cfg = cfg_ch.data;
          default: ;
        endcase
      end

      // input transaction
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        produced = deframe_byte(in_ch.in_byte, res);
        if (pin_active) begin
          produced = 1'b1;
          res      = pin_res;
        end
        if (produced)
          pending_results.push_back(res);
      end

      // result transaction
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        seen.kind           = out_ch.kind;
        seen.frame_flags    = out_ch.frame_flags;
        seen.stream_number  = out_ch.stream_number;
        seen.payload_length = out_ch.payload_length;
        seen.out_byte       = out_ch.out_byte;
        seen.last           = out_ch.last;
        seen.err_cause      = out_ch.err_cause;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (seen.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", seen.kind, want.kind));
          if (seen.frame_flags !== want.frame_flags)
            report_mismatch($sformatf("frame_flags %h, expected %h",
                                      seen.frame_flags, want.frame_flags));
          if (seen.stream_number !== want.stream_number)
            report_mismatch($sformatf("stream_number %h, expected %h",
                                      seen.stream_number, want.stream_number));
          if (seen.payload_length !== want.payload_length)
            report_mismatch($sformatf("payload_length %h, expected %h",
                                      seen.payload_length, want.payload_length));
          if (seen.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %h, expected %h",
                                      seen.out_byte, want.out_byte));
          if (seen.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", seen.last, want.last));
          if (seen.err_cause !== want.err_cause)
            report_mismatch($sformatf("err_cause %b, expected %b",
                                      seen.err_cause, want.err_cause));
        end
      end
    end
  end

  // result receiver: random idling plus long stalls on request
  initial begin : receiver
    int hold_served;
    int hold_left;
    hold_served  = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // one input transaction, entered and left at a falling edge
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
    items_sent++;
  endtask

  // stop sending, let all results drain and the block go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : timeout
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    logic [BYTE_W-1:0]   stim_magic;
    logic [LEN_W-1:0]    stim_max;
    logic [LEN_W-1:0]    cap;
    logic [LEN_W-1:0]    len;
    logic [BYTE_W-1:0]   magic;
    logic [8*HEADER_BYTES-1:0] hdr;
    bit                  mid_write;
    bit                  first;
    int                  phase;
    int                  phase_end;
    int                  pick;
    ending_t             ending;

    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    rst_n         = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table at reset register values
    send_idle_pct = 32;
    recv_idle_pct = 60;
    foreach (DIRECTED_ROWS[i]) begin
      pin_active = DIRECTED_ROWS[i].pinned;
      pin_res    = DIRECTED_ROWS[i].want;
      push_byte(DIRECTED_ROWS[i].data);
    end
    pin_active = 1'b0;

    // random frames, a new register setting per phase, extremes first
    items_sent = 0;
    for (phase = 0; items_sent < RANDOM_ITEMS; phase++) begin
      settle();
      case (phase)
        0: begin stim_magic = 8'hFF; stim_max = '0; end
        1: begin stim_magic = 8'h00; stim_max = 32'hFFFF_FFFF; end
        2: begin stim_magic = 8'($urandom); stim_max = MAX_PAYLOAD_RST; end
        default: begin
          stim_magic = 8'($urandom);
          stim_max   = $urandom_range(0, 80);
        end
      endcase
      write_reg(CFG_FRAME_MAGIC, stim_magic);
      write_reg(CFG_MAX_PAYLOAD, stim_max);
      write_reg(CFG_IDX_UNUSED, $urandom);

      phase_end = items_sent + PHASE_ITEMS;
      first     = 1'b1;
      while (items_sent < phase_end) begin
        // receiver idles more first, then sender, then neither
        if (items_sent < 700) begin
          send_idle_pct = 32;
          recv_idle_pct = 60;
        end else if (items_sent < 1400) begin
          send_idle_pct = 60;
          recv_idle_pct = 32;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end

        // payload length within the limit, boundary and zero often
        cap = (stim_max < 64) ? stim_max : 32'd64;
        if (stim_max >= 300 && $urandom_range(19) == 0)
          cap = 300;
        pick = $urandom_range(7);
        if (pick == 0)
          len = '0;
        else if (pick == 1)
          len = cap;
        else
          len = $urandom_range(0, cap);

        // long receiver stall over a long frame
        if (phase == 2 && first) begin
          hold_requests++;
          len = 60;
        end
        mid_write = (phase >= 3 && first && $urandom_range(1) == 1);
        first     = 1'b0;

        hdr = {stim_magic, 8'($urandom), {$urandom, $urandom}, len};
        for (int i = 0; i < HEADER_BYTES; i++) begin
          push_byte(hdr[8*(HEADER_BYTES-1-i) +: 8]);
          // registers changed mid-header: old magic already checked,
          // the new limit still covers this frame
          if (mid_write && i == 4) begin
            settle();
            stim_magic = 8'($urandom);
            stim_max   = len + $urandom_range(0, 40);
            write_reg(CFG_FRAME_MAGIC, stim_magic);
            write_reg(CFG_MAX_PAYLOAD, stim_max);
          end
        end
        for (int k = 0; k < len; k++)
          push_byte(8'($urandom));
      end
    end

    // closing protocol error, then bytes that the halted block drops
    settle();
    ending = ending_t'($urandom_range(2));
    case (ending)
      END_BAD_MAGIC: begin
        magic = stim_magic ^ 8'($urandom_range(1, 255));
        hdr   = {magic, 8'($urandom), {$urandom, $urandom}, 32'($urandom)};
      end
      END_TOO_LARGE: begin
        stim_max = ($urandom_range(3) == 0) ? 32'hFFFF_FFFE : $urandom_range(0, 1000);
        write_reg(CFG_MAX_PAYLOAD, stim_max);
        len = (stim_max > 1000) ? 32'hFFFF_FFFF : stim_max + 1 + $urandom_range(0, 1000);
        hdr = {stim_magic, 8'($urandom), {$urandom, $urandom}, len};
      end
      default: begin
        for (int i = 0; i < HEADER_BYTES; i++)
          hdr[8*i +: 8] = 8'($urandom);
      end
    endcase
    for (int i = 0; i < HEADER_BYTES; i++)
      push_byte(hdr[8*(HEADER_BYTES-1-i) +: 8]);
    for (int i = 0; i < 40; i++)
      push_byte(8'($urandom));

    // drain and finish
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
